// ===== src/tle_pkg.sv =====
// ----------------------------------------------------------------------------
// tle_pkg
// Character codes and result kinds shared by the terminal line editor.
// ----------------------------------------------------------------------------
package tle_pkg;

	typedef logic [7:0] char_t;
	typedef logic [2:0] kind_t;

	// control characters seen on the receive side
	localparam char_t CH_BS     = 8'h08;
	localparam char_t CH_DEL    = 8'h7f;
	localparam char_t CH_CTRL_W = 8'h17;
	localparam char_t CH_CTRL_U = 8'h15;
	localparam char_t CH_CR     = 8'h0d;
	localparam char_t CH_LF     = 8'h0a;
	localparam char_t CH_SPACE  = 8'h20;
	localparam char_t CH_TAB    = 8'h09;

	// result kinds
	localparam kind_t K_ECHO     = 3'd0;
	localparam kind_t K_BELL     = 3'd1;
	localparam kind_t K_ERASE    = 3'd2;
	localparam kind_t K_LINE_END = 3'd3;
	localparam kind_t K_READ     = 3'd4;
	localparam kind_t K_EMPTY    = 3'd5;
	localparam kind_t K_DROP     = 3'd6;

	// request codes on func
	localparam logic FUNC_RX   = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	function automatic logic is_white(input char_t c);
		is_white = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

endpackage

// ===== src/terminal_line_editor_core.sv =====
// ----------------------------------------------------------------------------
// terminal_line_editor_core
// Terminal line editor: collects received bytes in a ring store, handles
// erase, word erase, line kill and carriage return, drains finished lines.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid/in_ready) carries one request per beat:
// func 0 with a received byte in rx_byte, or func 1 to read one character of
// a completed line. Every request gives exactly one result beat on the
// output channel (out_valid/out_ready): kind, byte, erase count, line ready
// flag and fill level after the request.
// An accepted request passes to the done state, and its result is loaded into
// the output register from there; a read first passes the read state, which
// takes the registered store data. Word erase walks back through the store
// one character at a time, each step giving the address, then checking the
// registered data; it stops at a white-space character or when the line is
// empty.
// in_ready is high only while the sequencer is idle; a new request is taken
// while the previous result still waits in the output register, but its own
// result waits until that register is free. A stalled receiver thus holds
// at most one finished and one pending result.
// Reset clears the pointers, the fill count, the line flag and the output
// valid; the store itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module terminal_line_editor_core
	import tle_pkg::*;
#(
	parameter int DEPTH = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       func,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] out_kind,
	output logic [7:0] out_byte,
	output logic [6:0] erase_count,
	output logic       line_ready,
	output logic [6:0] fill_level
);

	localparam int PTR_W = $clog2(DEPTH);

	localparam logic [PTR_W-1:0] LAST_IDX  = PTR_W'(DEPTH - 1);
	localparam logic [PTR_W-1:0] FULL_CNT  = PTR_W'(DEPTH - 2);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_RD     = 3'd1;
	localparam logic [2:0] ST_WE_RD  = 3'd2;
	localparam logic [2:0] ST_WE_CHK = 3'd3;
	localparam logic [2:0] ST_DONE   = 3'd4;

	logic [2:0]       state_q;
	logic [PTR_W-1:0] rp_q, wp_q, cnt_q;
	logic             lc_q;
	kind_t            res_kind_q;
	char_t            res_byte_q;
	logic [PTR_W-1:0] res_erased_q;

	char_t            mem [DEPTH];
	char_t            rd_data_q;
	logic             mem_we;
	logic [PTR_W-1:0] mem_addr;

	logic             out_valid_q;
	kind_t            out_kind_q;
	char_t            out_byte_q;
	logic [6:0]       erase_count_q;
	logic             line_ready_q;
	logic [6:0]       fill_level_q;

	logic [PTR_W-1:0] wp_next, wp_prev, rp_next;
	logic             accept;

	assign wp_next = (wp_q == LAST_IDX) ? '0 : wp_q + 1'b1;
	assign wp_prev = (wp_q == '0) ? LAST_IDX : wp_q - 1'b1;
	assign rp_next = (rp_q == LAST_IDX) ? '0 : rp_q + 1'b1;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// store port: writes at the write pointer, reads either side of the line
	always_comb begin
		mem_we   = 1'b0;
		mem_addr = wp_q;
		if (accept && func == FUNC_RX && !lc_q) begin
			if (rx_byte == CH_CR) begin
				mem_we = 1'b1;
			end else if (rx_byte != CH_BS && rx_byte != CH_DEL &&
			             rx_byte != CH_CTRL_W && rx_byte != CH_CTRL_U &&
			             cnt_q < FULL_CNT) begin
				mem_we = 1'b1;
			end
		end else if (accept && func == FUNC_READ) begin
			mem_addr = rp_q;
		end else if (state_q == ST_WE_RD) begin
			mem_addr = wp_prev;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= (rx_byte == CH_CR) ? CH_LF : rx_byte;
		end
		rd_data_q <= mem[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rp_q         <= '0;
			wp_q         <= '0;
			cnt_q        <= '0;
			lc_q         <= 1'b0;
			res_kind_q   <= K_EMPTY;
			res_byte_q   <= '0;
			res_erased_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_byte_q   <= '0;
						res_erased_q <= '0;
						state_q      <= ST_DONE;
						if (func == FUNC_READ) begin
							if (lc_q && cnt_q != '0) begin
								state_q <= ST_RD;
							end else begin
								res_kind_q <= K_EMPTY;
							end
						end else if (lc_q) begin
							res_kind_q <= K_DROP;
						end else if (rx_byte == CH_CR) begin
							wp_q       <= wp_next;
							cnt_q      <= cnt_q + 1'b1;
							lc_q       <= 1'b1;
							res_kind_q <= K_LINE_END;
						end else if (rx_byte == CH_BS || rx_byte == CH_DEL) begin
							if (cnt_q == '0) begin
								res_kind_q <= K_BELL;
							end else begin
								wp_q         <= wp_prev;
								cnt_q        <= cnt_q - 1'b1;
								res_erased_q <= PTR_W'(1);
								res_kind_q   <= K_ERASE;
							end
						end else if (rx_byte == CH_CTRL_W) begin
							res_kind_q <= K_ERASE;
							state_q    <= ST_WE_RD;
						end else if (rx_byte == CH_CTRL_U) begin
							// the line always spans read pointer to write pointer
							wp_q         <= rp_q;
							cnt_q        <= '0;
							res_erased_q <= cnt_q;
							res_kind_q   <= K_ERASE;
						end else if (cnt_q >= FULL_CNT) begin
							res_kind_q <= K_BELL;
						end else begin
							wp_q       <= wp_next;
							cnt_q      <= cnt_q + 1'b1;
							res_byte_q <= rx_byte;
							res_kind_q <= K_ECHO;
						end
					end
				end
				ST_RD: begin
					res_byte_q <= rd_data_q;
					res_kind_q <= K_READ;
					rp_q       <= rp_next;
					cnt_q      <= cnt_q - 1'b1;
					if (cnt_q == PTR_W'(1)) begin
						lc_q <= 1'b0;
					end
					state_q <= ST_DONE;
				end
				ST_WE_RD: begin
					// address of the last stored character goes out this cycle
					if (cnt_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_WE_CHK;
					end
				end
				ST_WE_CHK: begin
					if (is_white(rd_data_q)) begin
						state_q <= ST_DONE;
					end else begin
						wp_q         <= wp_prev;
						cnt_q        <= cnt_q - 1'b1;
						res_erased_q <= res_erased_q + 1'b1;
						state_q      <= ST_WE_RD;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register, loaded once the previous beat has left
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
			out_kind_q    <= res_kind_q;
			out_byte_q    <= res_byte_q;
			erase_count_q <= 7'(res_erased_q);
			line_ready_q  <= lc_q;
			fill_level_q  <= 7'(cnt_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign out_kind    = out_kind_q;
	assign out_byte    = out_byte_q;
	assign erase_count = erase_count_q;
	assign line_ready  = line_ready_q;
	assign fill_level  = fill_level_q;

endmodule
